/* design/hgap_pkg.sv */
package hgap_pkg;

  // Fixed field widths of the item channels and the configuration register.
  localparam int CMD_W    = 2;
  localparam int CELL_W   = 10;
  localparam int STATUS_W = 2;
  localparam int RAD_W    = 5;

  localparam logic [RAD_W-1:0] RAD_RESET = 5'd16;

  localparam int NUM_DIRS = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET  = 2'd0,
    CMD_FIND = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } hgap_cmd_t;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_PATH = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD     = 2'd2;

  // Per-cell search mark: bit 0 is open, bit 1 is closed.
  localparam logic [1:0] MARK_FREE   = 2'b00;
  localparam logic [1:0] MARK_OPEN   = 2'b01;
  localparam logic [1:0] MARK_CLOSED = 2'b10;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_SIZE, ST_DECODE, ST_DIV, ST_EXIST, ST_MCLR,
    ST_INIT_GO, ST_INIT_WAIT, ST_SCAN, ST_CLOSE, ST_CLOSE2, ST_NB0, ST_NB1,
    ST_NB2, ST_NB_GO, ST_NB_WAIT, ST_P0, ST_P1, ST_W0, ST_W1, ST_RD0, ST_RD1,
    ST_DONE
  } hgap_state_t;

  typedef enum logic [1:0] {
    HS_IDLE, HS_MUL, HS_SUM, HS_ROOT
  } hgap_hstate_t;

  // Axial step of each of the six neighbor directions.
  function automatic logic signed [1:0] step_q(input logic [2:0] d);
    logic signed [1:0] v;
    case (d)
      3'd1, 3'd2: v = -2'sd1;
      3'd4, 3'd5: v = 2'sd1;
      default:    v = 2'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [1:0] step_r(input logic [2:0] d);
    logic signed [1:0] v;
    case (d)
      3'd0, 3'd1: v = 2'sd1;
      3'd3, 3'd4: v = -2'sd1;
      default:    v = 2'sd0;
    endcase
    return v;
  endfunction

endpackage

/* design/hgap_req_if.sv */
interface hgap_req_if;
  import hgap_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CELL_W-1:0] cell_req;
  logic [CELL_W-1:0] goal_cell;
  logic              blocked;
  logic [CELL_W-1:0] position;

  modport source (output valid, cmd, cell_req, goal_cell, blocked, position, input ready);
  modport sink (input valid, cmd, cell_req, goal_cell, blocked, position, output ready);
endinterface

/* design/hgap_rsp_if.sv */
interface hgap_rsp_if;
  import hgap_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CELL_W-1:0]   path_length;
  logic [CELL_W-1:0]   path_cell;

  modport source (output valid, status, path_length, path_cell, input ready);
  modport sink (input valid, status, path_length, path_cell, output ready);
endinterface

/* design/hgap_ram.sv */
module hgap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/hgap_heur.sv */
module hgap_heur #(
  parameter int MAX_RADIUS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [$clog2(2*MAX_RADIUS):0]  dq,
  input  logic signed [$clog2(2*MAX_RADIUS):0]  dr,
  output logic                                  done,
  output logic [((2*$clog2(2*MAX_RADIUS)+13)+1)/2-1:0] h
);
  import hgap_pkg::*;

  localparam int XW  = $clog2(2*MAX_RADIUS);
  localparam int PDW = 2*XW + 3;
  localparam int VW  = PDW + 10;
  localparam int HW  = (VW + 1) / 2;
  localparam int SW  = 2 * HW;
  localparam int NW  = $clog2(HW + 1);

  hgap_hstate_t          hs, hs_next;
  logic signed [XW:0]    aq, ar, aq_next, ar_next;
  logic signed [PDW-1:0] t1, t1_next, dsum;
  logic [SW-1:0]         rem, res, bitv, rem_next, res_next, bitv_next;
  logic [NW-1:0]         cnt, cnt_next;
  logic                  done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hs   <= HS_IDLE;
      done <= 1'b0;
    end else begin
      hs   <= hs_next;
      done <= done_next;
    end
    aq   <= aq_next;
    ar   <= ar_next;
    t1   <= t1_next;
    rem  <= rem_next;
    res  <= res_next;
    bitv <= bitv_next;
    cnt  <= cnt_next;
  end

  assign h = res[HW-1:0];

  // Distance term, then a digit-by-digit square root of 768 times it.
  always_comb begin
    hs_next   = hs;
    aq_next   = aq;
    ar_next   = ar;
    t1_next   = t1;
    rem_next  = rem;
    res_next  = res;
    bitv_next = bitv;
    cnt_next  = cnt;
    done_next = 1'b0;
    dsum      = t1 + PDW'(ar) * PDW'(ar);
    unique case (hs)
      HS_IDLE: begin
        if (start) begin
          aq_next = dq;
          ar_next = dr;
          hs_next = HS_MUL;
        end
      end
      HS_MUL: begin
        t1_next = PDW'(aq) * (PDW'(aq) + PDW'(ar));
        hs_next = HS_SUM;
      end
      HS_SUM: begin
        rem_next  = (SW'(unsigned'(dsum)) << 9) + (SW'(unsigned'(dsum)) << 8);
        res_next  = '0;
        bitv_next = SW'(1) << (SW - 2);
        cnt_next  = '0;
        hs_next   = HS_ROOT;
      end
      HS_ROOT: begin
        if (rem >= res + bitv) begin
          rem_next = rem - (res + bitv);
          res_next = (res >> 1) + bitv;
        end else begin
          res_next = res >> 1;
        end
        bitv_next = bitv >> 2;
        cnt_next  = cnt + NW'(1);
        if (cnt == NW'(HW - 1)) begin
          done_next = 1'b1;
          hs_next   = HS_IDLE;
        end
      end
      default: hs_next = HS_IDLE;
    endcase
  end

endmodule

/* design/hex_grid_astar_path_core.sv */
module hex_grid_astar_path_core #(
  parameter int MAX_RADIUS = 16,
  parameter int CELL_SLOTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [hgap_pkg::RAD_W-1:0]  cfg_data,
  hgap_req_if.sink                    req,
  hgap_rsp_if.source                  rsp
);
  // A* path search on a hex grid kept in axial coordinates. Every item gives
  // exactly one result item, and the block takes one item at a time. After
  // reset a clearing pass writes the blocked map, one cell a cycle, during
  // which no item is accepted. A set or a find turns its cell index into
  // coordinates by repeated subtraction of the array side. A find first clears
  // the search marks over the N = (2R-1)^2 array cells, then for every cell it
  // expands it scans all N cells through the mark and priority memories at
  // one cell a cycle and checks six neighbors, each using the shared heuristic
  // unit when its cost improves (HW = 12 square-root steps at radius 16). The
  // path is then written by walking the parent chain back from the goal.
  import hgap_pkg::*;

  localparam int IW  = $clog2(CELL_SLOTS);
  localparam int CNW = IW + 1;
  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int XW  = $clog2(2*MAX_RADIUS);
  localparam int CW  = 2 * XW;
  localparam int EW  = XW + 2;
  localparam int LW  = (CNW > CELL_W) ? CNW : CELL_W;
  localparam int PDW = 2*XW + 3;
  localparam int VW  = PDW + 10;
  localparam int HW  = (VW + 1) / 2;
  localparam int PW  = ((IW + 4 > HW) ? IW + 4 : HW) + 1;

  // Registers.
  hgap_state_t        state, state_next;
  logic [RAD_W-1:0]   grid_radius, grid_radius_next;
  logic [IW-1:0]      cnt, cnt_next;
  hgap_cmd_t          cmd_r, cmd_r_next;
  logic [CELL_W-1:0]  cell_r, cell_r_next, goal_r, goal_r_next, pos_r, pos_r_next;
  logic               blk_r, blk_r_next;
  logic [RW-1:0]      rad, rad_next;
  logic [XW-1:0]      side, side_next;
  logic [CNW-1:0]     cells, cells_next;
  logic [LW-1:0]      rem, rem_next;
  logic [XW-1:0]      quo, quo_next;
  logic               sel, sel_next;
  logic [XW-1:0]      xs, ys, xg, yg, xs_next, ys_next, xg_next, yg_next;
  logic [XW-1:0]      hx, hy, hx_next, hy_next;
  logic [CNW-1:0]     si, si_next;
  logic [XW-1:0]      scx, scy, scx_next, scy_next;
  logic               pv, pv_next;
  logic [IW-1:0]      pi, pi_next;
  logic [XW-1:0]      px, py, px_next, py_next;
  logic               found, found_next;
  logic [IW-1:0]      best, best_next;
  logic [XW-1:0]      bx, by, bx_next, by_next;
  logic [PW-1:0]      bestp, bestp_next;
  logic [IW-1:0]      gbest, gbest_next;
  logic [2:0]         dir, dir_next;
  logic [CW-1:0]      nfull, nfull_next;
  logic               gblk, gblk_next;
  logic [IW-1:0]      k, k_next, pn, pn_next, ppos, ppos_next, pcount, pcount_next;
  logic [STATUS_W-1:0] status, status_next;
  logic [IW-1:0]      pcell, pcell_next;
  logic               out_valid, out_valid_next;
  logic [STATUS_W-1:0] o_status, o_status_next;
  logic [CELL_W-1:0]  o_len, o_len_next, o_cell, o_cell_next;

  // Memory ports.
  logic            blk_we, blk_wd, blk_rd;
  logic [IW-1:0]   blk_wa, blk_ra;
  logic            mark_we;
  logic [1:0]      mark_wd, mark_rd;
  logic [IW-1:0]   mark_wa, mark_ra;
  logic            cost_we;
  logic [IW-1:0]   cost_wd, cost_rd, cost_wa, cost_ra;
  logic            par_we;
  logic [IW:0]     par_wd, par_rd;
  logic [IW-1:0]   par_wa, par_ra;
  logic            prio_we;
  logic [PW-1:0]   prio_wd, prio_rd;
  logic [IW-1:0]   prio_wa, prio_ra;
  logic            ps_we;
  logic [IW-1:0]   ps_wd, ps_rd, ps_wa, ps_ra;

  // Heuristic unit.
  logic               heur_start, heur_done;
  logic [HW-1:0]      heur_h;
  logic signed [XW:0] heur_dq, heur_dr;

  // Working values.
  logic [IW-1:0]      sidx, gidx, nidx;
  logic signed [XW:0] nx, ny;
  logic               nb_ok, nb_skip, scan_init, finish;
  logic [IW:0]        g;
  logic [CW-1:0]      sq;

  hgap_ram #(.WIDTH(1), .DEPTH(CELL_SLOTS)) u_blk (
    .clk(clk), .we(blk_we), .waddr(blk_wa), .wdata(blk_wd), .raddr(blk_ra), .rdata(blk_rd));
  hgap_ram #(.WIDTH(2), .DEPTH(CELL_SLOTS)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd), .raddr(mark_ra),
    .rdata(mark_rd));
  hgap_ram #(.WIDTH(IW), .DEPTH(CELL_SLOTS)) u_cost (
    .clk(clk), .we(cost_we), .waddr(cost_wa), .wdata(cost_wd), .raddr(cost_ra),
    .rdata(cost_rd));
  hgap_ram #(.WIDTH(IW+1), .DEPTH(CELL_SLOTS)) u_par (
    .clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd), .raddr(par_ra), .rdata(par_rd));
  hgap_ram #(.WIDTH(PW), .DEPTH(CELL_SLOTS)) u_prio (
    .clk(clk), .we(prio_we), .waddr(prio_wa), .wdata(prio_wd), .raddr(prio_ra),
    .rdata(prio_rd));
  hgap_ram #(.WIDTH(IW), .DEPTH(CELL_SLOTS)) u_path (
    .clk(clk), .we(ps_we), .waddr(ps_wa), .wdata(ps_wd), .raddr(ps_ra), .rdata(ps_rd));

  hgap_heur #(.MAX_RADIUS(MAX_RADIUS)) u_heur (
    .clk(clk), .rst(rst), .start(heur_start), .dq(heur_dq), .dr(heur_dr),
    .done(heur_done), .h(heur_h));

  // A cell lies inside the hexagon when R-1 <= x+y <= 3R-3.
  function automatic logic hex_ok(input logic [XW:0] s, input logic [RW-1:0] r);
    return (EW'(s) + EW'(1) >= EW'(r)) && (EW'(s) + EW'(3) <= EW'(3) * EW'(r));
  endfunction

  assign sidx    = IW'(cell_r);
  assign gidx    = IW'(goal_r);
  assign nidx    = IW'(nfull);
  assign heur_dq = $signed({1'b0, hx}) - $signed({1'b0, xg});
  assign heur_dr = $signed({1'b0, hy}) - $signed({1'b0, yg});
  assign nx      = $signed({1'b0, bx}) + (XW+1)'(step_q(dir));
  assign ny      = $signed({1'b0, by}) + (XW+1)'(step_r(dir));
  assign nb_ok   = !nx[XW] && !ny[XW] && (nx[XW-1:0] < side) && (ny[XW-1:0] < side)
                   && hex_ok((XW+1)'(nx[XW-1:0]) + (XW+1)'(ny[XW-1:0]), rad);
  assign g       = (IW+1)'(gbest) + (IW+1)'(1);
  assign sq      = CW'(side) * CW'(side);

  assign req.ready       = (state == ST_IDLE) && !out_valid;
  assign rsp.valid       = out_valid;
  assign rsp.status      = o_status;
  assign rsp.path_length = o_len;
  assign rsp.path_cell   = o_cell;

  // State register and item registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cnt         <= '0;
      pcount      <= '0;
      out_valid   <= 1'b0;
      grid_radius <= RAD_RESET;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      pcount      <= pcount_next;
      out_valid   <= out_valid_next;
      grid_radius <= grid_radius_next;
    end
    cmd_r    <= cmd_r_next;
    cell_r   <= cell_r_next;
    goal_r   <= goal_r_next;
    pos_r    <= pos_r_next;
    blk_r    <= blk_r_next;
    rad      <= rad_next;
    side     <= side_next;
    cells    <= cells_next;
    rem      <= rem_next;
    quo      <= quo_next;
    sel      <= sel_next;
    xs       <= xs_next;
    ys       <= ys_next;
    xg       <= xg_next;
    yg       <= yg_next;
    hx       <= hx_next;
    hy       <= hy_next;
    si       <= si_next;
    scx      <= scx_next;
    scy      <= scy_next;
    pv       <= pv_next;
    pi       <= pi_next;
    px       <= px_next;
    py       <= py_next;
    found    <= found_next;
    best     <= best_next;
    bx       <= bx_next;
    by       <= by_next;
    bestp    <= bestp_next;
    gbest    <= gbest_next;
    dir      <= dir_next;
    nfull    <= nfull_next;
    gblk     <= gblk_next;
    k        <= k_next;
    pn       <= pn_next;
    ppos     <= ppos_next;
    status   <= status_next;
    pcell    <= pcell_next;
    o_status <= o_status_next;
    o_len    <= o_len_next;
    o_cell   <= o_cell_next;
  end

  // Sequencer: next state, datapath updates and memory controls.
  always_comb begin
    state_next       = state;
    grid_radius_next = cfg_we ? cfg_data : grid_radius;
    cnt_next    = cnt;
    cmd_r_next  = cmd_r;
    cell_r_next = cell_r;
    goal_r_next = goal_r;
    pos_r_next  = pos_r;
    blk_r_next  = blk_r;
    rad_next    = rad;
    side_next   = side;
    cells_next  = cells;
    rem_next    = rem;
    quo_next    = quo;
    sel_next    = sel;
    xs_next     = xs;
    ys_next     = ys;
    xg_next     = xg;
    yg_next     = yg;
    hx_next     = hx;
    hy_next     = hy;
    si_next     = si;
    scx_next    = scx;
    scy_next    = scy;
    pv_next     = pv;
    pi_next     = pi;
    px_next     = px;
    py_next     = py;
    found_next  = found;
    best_next   = best;
    bx_next     = bx;
    by_next     = by;
    bestp_next  = bestp;
    gbest_next  = gbest;
    dir_next    = dir;
    nfull_next  = nfull;
    gblk_next   = gblk;
    k_next      = k;
    pn_next     = pn;
    ppos_next   = ppos;
    pcount_next = pcount;
    status_next = status;
    pcell_next  = pcell;
    out_valid_next = out_valid;
    o_status_next  = o_status;
    o_len_next     = o_len;
    o_cell_next    = o_cell;

    blk_we  = 1'b0;  blk_wa  = cnt;   blk_wd  = 1'b0;  blk_ra  = best;
    mark_we = 1'b0;  mark_wa = cnt;   mark_wd = MARK_FREE;  mark_ra = si[IW-1:0];
    cost_we = 1'b0;  cost_wa = nidx;  cost_wd = IW'(g);      cost_ra = best;
    par_we  = 1'b0;  par_wa  = nidx;  par_wd  = {1'b0, best}; par_ra = pn;
    prio_we = 1'b0;  prio_wa = nidx;  prio_ra = si[IW-1:0];
    prio_wd = (PW'(g) << 4) + PW'(heur_h);
    ps_we   = 1'b0;  ps_wa   = ppos;  ps_wd   = pn;  ps_ra = IW'(pos_r);
    heur_start = 1'b0;
    nb_skip    = 1'b0;
    scan_init  = 1'b0;
    finish     = 1'b0;

    if (rsp.valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      // Sweep the blocked map clear after reset.
      ST_CLEAR: begin
        blk_we = 1'b1;
        if (cnt == IW'(CELL_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + IW'(1);
        end
      end
      ST_IDLE: begin
        if (req.valid && req.ready) begin
          cmd_r_next  = hgap_cmd_t'(req.cmd);
          cell_r_next = req.cell_req;
          goal_r_next = req.goal_cell;
          blk_r_next  = req.blocked;
          pos_r_next  = req.position;
          status_next = STAT_OK;
          pcell_next  = '0;
          state_next  = ST_SETUP;
        end
      end
      // Clamp the radius and derive the array side and cell count.
      ST_SETUP: begin
        if (32'(grid_radius) > MAX_RADIUS) begin
          rad_next = RW'(MAX_RADIUS);
        end else if (grid_radius == '0) begin
          rad_next = RW'(1);
        end else begin
          rad_next = RW'(grid_radius);
        end
        side_next  = XW'({rad_next, 1'b0} - (RW+1)'(1));
        state_next = ST_SIZE;
      end
      ST_SIZE: begin
        cells_next = (32'(sq) > CELL_SLOTS) ? CNW'(CELL_SLOTS) : CNW'(sq);
        state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (cmd_r)
          CMD_SET, CMD_FIND: begin
            if (LW'(cell_r) < LW'(cells)) begin
              rem_next   = LW'(cell_r);
              quo_next   = '0;
              sel_next   = 1'b0;
              state_next = ST_DIV;
            end else begin
              status_next = STAT_BAD;
              finish      = 1'b1;
            end
          end
          CMD_READ: state_next = ST_RD0;
          default:  finish = 1'b1;
        endcase
      end
      // Index to coordinates by repeated subtraction of the side.
      ST_DIV: begin
        if (rem >= LW'(side)) begin
          rem_next = rem - LW'(side);
          quo_next = quo + XW'(1);
        end else begin
          state_next = ST_EXIST;
        end
      end
      ST_EXIST: begin
        if (!hex_ok((XW+1)'(XW'(rem)) + (XW+1)'(quo), rad)) begin
          status_next = STAT_BAD;
          finish      = 1'b1;
        end else if (cmd_r == CMD_SET) begin
          blk_we = 1'b1;
          blk_wa = sidx;
          blk_wd = blk_r;
          finish = 1'b1;
        end else if (!sel) begin
          xs_next = XW'(rem);
          ys_next = quo;
          if (LW'(goal_r) < LW'(cells)) begin
            rem_next   = LW'(goal_r);
            quo_next   = '0;
            sel_next   = 1'b1;
            state_next = ST_DIV;
          end else begin
            status_next = STAT_BAD;
            finish      = 1'b1;
          end
        end else begin
          xg_next    = XW'(rem);
          yg_next    = quo;
          cnt_next   = '0;
          state_next = ST_MCLR;
        end
      end
      // Clear the search marks over the array.
      ST_MCLR: begin
        mark_we = 1'b1;
        if (CNW'(cnt) == cells - CNW'(1)) begin
          hx_next    = xs;
          hy_next    = ys;
          state_next = ST_INIT_GO;
        end else begin
          cnt_next = cnt + IW'(1);
        end
      end
      ST_INIT_GO: begin
        heur_start = 1'b1;
        state_next = ST_INIT_WAIT;
      end
      ST_INIT_WAIT: begin
        if (heur_done) begin
          mark_we = 1'b1;  mark_wa = sidx;  mark_wd = MARK_OPEN;
          cost_we = 1'b1;  cost_wa = sidx;  cost_wd = '0;
          par_we  = 1'b1;  par_wa  = sidx;  par_wd  = {1'b1, IW'(0)};
          prio_we = 1'b1;  prio_wa = sidx;  prio_wd = PW'(heur_h);
          scan_init = 1'b1;
        end
      end
      // Find the open cell of lowest priority, lower index first on ties.
      ST_SCAN: begin
        if (pv && mark_rd[0] && (!found || prio_rd < bestp)) begin
          found_next = 1'b1;
          best_next  = pi;
          bx_next    = px;
          by_next    = py;
          bestp_next = prio_rd;
        end
        pv_next = (si < cells);
        if (si < cells) begin
          si_next = si + CNW'(1);
          pi_next = si[IW-1:0];
          px_next = scx;
          py_next = scy;
          if (scx == side - XW'(1)) begin
            scx_next = '0;
            scy_next = scy + XW'(1);
          end else begin
            scx_next = scx + XW'(1);
          end
        end else if (!pv) begin
          if (found) begin
            state_next = ST_CLOSE;
          end else begin
            pcount_next = '0;
            status_next = STAT_NO_PATH;
            finish      = 1'b1;
          end
        end
      end
      ST_CLOSE: begin
        mark_we    = 1'b1;
        mark_wa    = best;
        mark_wd    = MARK_CLOSED;
        state_next = ST_CLOSE2;
      end
      ST_CLOSE2: begin
        gbest_next = cost_rd;
        if (best == gidx) begin
          gblk_next  = blk_rd;
          pn_next    = gidx;
          state_next = ST_P0;
        end else begin
          dir_next   = '0;
          state_next = ST_NB0;
        end
      end
      // Neighbor checks.
      ST_NB0: begin
        if (nb_ok) begin
          nfull_next = CW'(ny[XW-1:0]) * CW'(side) + CW'(nx[XW-1:0]);
          hx_next    = nx[XW-1:0];
          hy_next    = ny[XW-1:0];
          state_next = ST_NB1;
        end else begin
          nb_skip = 1'b1;
        end
      end
      ST_NB1: begin
        blk_ra  = nidx;
        mark_ra = nidx;
        cost_ra = nidx;
        if (nfull < CW'(cells)) begin
          state_next = ST_NB2;
        end else begin
          nb_skip = 1'b1;
        end
      end
      ST_NB2: begin
        if ((blk_rd && nidx != gidx) || mark_rd[1]) begin
          nb_skip = 1'b1;
        end else if (!mark_rd[0] || (IW+1)'(cost_rd) > g) begin
          state_next = ST_NB_GO;
        end else begin
          nb_skip = 1'b1;
        end
      end
      ST_NB_GO: begin
        heur_start = 1'b1;
        state_next = ST_NB_WAIT;
      end
      ST_NB_WAIT: begin
        if (heur_done) begin
          mark_we = 1'b1;
          mark_wa = nidx;
          mark_wd = MARK_OPEN;
          cost_we = 1'b1;
          par_we  = 1'b1;
          prio_we = 1'b1;
          nb_skip = 1'b1;
        end
      end
      // Count the parent chain back from the goal.
      ST_P0: begin
        k_next     = '0;
        state_next = ST_P1;
      end
      ST_P1: begin
        if (par_rd[IW]) begin
          if (k == '0) begin
            pcount_next = '0;
            finish      = 1'b1;
          end else begin
            pn_next    = gidx;
            ppos_next  = k - IW'(1);
            state_next = ST_W0;
          end
        end else begin
          k_next  = k + IW'(1);
          pn_next = par_rd[IW-1:0];
          par_ra  = par_rd[IW-1:0];
        end
      end
      // Walk the chain again, filling the path from its end.
      ST_W0: begin
        ps_we      = !(pn == gidx && gblk);
        state_next = ST_W1;
      end
      ST_W1: begin
        if (ppos == '0) begin
          pcount_next = k - IW'(gblk);
          finish      = 1'b1;
        end else begin
          ppos_next  = ppos - IW'(1);
          pn_next    = par_rd[IW-1:0];
          state_next = ST_W0;
        end
      end
      ST_RD0: begin
        if (LW'(pos_r) < LW'(pcount)) begin
          state_next = ST_RD1;
        end else begin
          status_next = STAT_BAD;
          finish      = 1'b1;
        end
      end
      ST_RD1: begin
        pcell_next = ps_rd;
        finish     = 1'b1;
      end
      ST_DONE: begin
        out_valid_next = 1'b1;
        o_status_next  = status;
        o_len_next     = CELL_W'(pcount);
        o_cell_next    = CELL_W'(pcell);
        state_next     = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    // Move to the next direction, or back to selection after the sixth.
    if (nb_skip) begin
      if (dir == 3'(NUM_DIRS - 1)) begin
        scan_init = 1'b1;
      end else begin
        dir_next   = dir + 3'd1;
        state_next = ST_NB0;
      end
    end
    if (scan_init) begin
      si_next    = '0;
      pv_next    = 1'b0;
      found_next = 1'b0;
      scx_next   = '0;
      scy_next   = '0;
      state_next = ST_SCAN;
    end
    if (finish) begin
      state_next = ST_DONE;
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import hgap_pkg::*;

  localparam int SLOTS      = 1024;
  localparam int TOP_RADIUS = 16;
  localparam int NO_PARENT  = -1;
  localparam int CYCLE_CAP  = 60000000;
  localparam int DRAIN_WAIT = 64;

  // Sender and receiver behavior of one phase.
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    hgap_cmd_t         cmd;
    logic [CELL_W-1:0] cell_idx;
    logic [CELL_W-1:0] goal;
    logic              blk;
    logic [CELL_W-1:0] pos;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CELL_W-1:0]   length;
    logic [CELL_W-1:0]   pcell;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [RAD_W-1:0]    cfg_data = '0;

  hgap_req_if req ();
  hgap_rsp_if rsp ();

  hex_grid_astar_path_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req.sink),
    .rsp      (rsp.source)
  );

  always #5 clk = ~clk;

  request_t   pending_q[$];
  reply_t     reply_q[$];
  idle_mode_t idle_mode = IDLE_NONE;
  logic       in_flight = 1'b0;
  int         mismatches = 0;
  int         cycles = 0;

  // Shadow copy of the grid and the search state.
  logic [RAD_W-1:0] sh_radius;
  logic             sh_blocked[SLOTS];
  logic             sh_open[SLOTS];
  logic             sh_closed[SLOTS];
  int               sh_cost[SLOTS];
  int               sh_parent[SLOTS];
  int               sh_prio[SLOTS];
  int               sh_route[SLOTS];
  int               sh_walk[SLOTS];
  int               sh_count;

  function automatic int radius_eff();
    int r;
    r = sh_radius;
    if (r < 1) r = 1;
    if (r > TOP_RADIUS) r = TOP_RADIUS;
    return r;
  endfunction

  function automatic int grid_side();
    return 2 * radius_eff() - 1;
  endfunction

  function automatic int grid_cells();
    int c;
    c = grid_side() * grid_side();
    return (c > SLOTS) ? SLOTS : c;
  endfunction

  function automatic int axial_q(int idx);
    return idx % grid_side() - (radius_eff() - 1);
  endfunction

  function automatic int axial_r(int idx);
    return idx / grid_side() - (radius_eff() - 1);
  endfunction

  function automatic bit on_grid(int idx);
    int s;
    if (idx < 0 || idx >= grid_cells()) return 0;
    s = axial_q(idx) + axial_r(idx);
    if (s < 0) s = -s;
    return s < radius_eff();
  endfunction

  function automatic int cell_of(int q, int r);
    int x, y, idx;
    x = q + radius_eff() - 1;
    y = r + radius_eff() - 1;
    if (x < 0 || x >= grid_side() || y < 0 || y >= grid_side()) return -1;
    idx = y * grid_side() + x;
    return on_grid(idx) ? idx : -1;
  endfunction

  function automatic int unsigned int_sqrt(int unsigned v);
    int unsigned res, bt;
    res = 0;
    bt = 32'h4000_0000;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // Hex distance estimate in fixed point with four fraction bits.
  function automatic int hex_estimate(int a, int b);
    int dq, dr, d;
    dq = axial_q(a) - axial_q(b);
    dr = axial_r(a) - axial_r(b);
    d = dq * dq + dq * dr + dr * dr;
    if (d < 0) d = 0;
    return int_sqrt(d * 768);
  endfunction

  // Walk back from the goal and store the route, leaving out blocked cells.
  function automatic void store_route(int goal);
    int n, k;
    n = goal;
    k = 0;
    while (sh_parent[n] != NO_PARENT && k < grid_cells()) begin
      sh_walk[k] = n;
      k++;
      n = sh_parent[n];
    end
    sh_count = 0;
    while (k > 0) begin
      k--;
      if (!sh_blocked[sh_walk[k]]) begin
        sh_route[sh_count] = sh_walk[k];
        sh_count++;
      end
    end
  endfunction

  function automatic logic [STATUS_W-1:0] route_search(int start, int goal);
    int cells, best, q, r, nb, g;
    cells = grid_cells();
    for (int i = 0; i < SLOTS; i++) begin
      sh_open[i] = 0;
      sh_closed[i] = 0;
    end
    sh_open[start] = 1;
    sh_cost[start] = 0;
    sh_parent[start] = NO_PARENT;
    sh_prio[start] = hex_estimate(start, goal);
    for (int it = 0; it <= cells; it++) begin
      best = -1;
      for (int i = 0; i < cells; i++)
        if (sh_open[i] && (best < 0 || sh_prio[i] < sh_prio[best])) best = i;
      if (best < 0) break;
      sh_open[best] = 0;
      sh_closed[best] = 1;
      if (best == goal) begin
        store_route(goal);
        return STAT_OK;
      end
      q = axial_q(best);
      r = axial_r(best);
      for (int d = 0; d < NUM_DIRS; d++) begin
        nb = cell_of(q + int'(step_q(3'(d))), r + int'(step_r(3'(d))));
        if (nb < 0) continue;
        if (sh_blocked[nb] && nb != goal) continue;
        if (sh_closed[nb]) continue;
        g = sh_cost[best] + 1;
        if (!sh_open[nb] || sh_cost[nb] > g) begin
          sh_open[nb] = 1;
          sh_cost[nb] = g;
          sh_parent[nb] = best;
          sh_prio[nb] = g * 16 + hex_estimate(nb, goal);
        end
      end
    end
    sh_count = 0;
    return STAT_NO_PATH;
  endfunction

  function automatic reply_t predict_reply(request_t it);
    reply_t rp;
    rp.status = STAT_OK;
    rp.pcell = '0;
    case (it.cmd)
      CMD_SET: begin
        if (on_grid(it.cell_idx)) sh_blocked[it.cell_idx] = it.blk;
        else rp.status = STAT_BAD;
      end
      CMD_FIND: begin
        if (on_grid(it.cell_idx) && on_grid(it.goal))
          rp.status = route_search(it.cell_idx, it.goal);
        else rp.status = STAT_BAD;
      end
      CMD_READ: begin
        if (it.pos < sh_count) rp.pcell = CELL_W'(sh_route[it.pos]);
        else rp.status = STAT_BAD;
      end
      default: ;
    endcase
    rp.length = CELL_W'(sh_count);
    return rp;
  endfunction

  // Driver: presents queued items at the falling edge and holds each until taken.
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      rsp.ready <= 1'b0;
    end else begin
      if (!in_flight) begin
        if (pending_q.size() != 0 &&
            !((idle_mode == IDLE_SEND && $urandom_range(99) < 83) ||
              (idle_mode == IDLE_BOTH && $urandom_range(99) < 18))) begin
          req.cmd       <= pending_q[0].cmd;
          req.cell_req  <= pending_q[0].cell_idx;
          req.goal_cell <= pending_q[0].goal;
          req.blocked   <= pending_q[0].blk;
          req.position  <= pending_q[0].pos;
          req.valid     <= 1'b1;
          in_flight     <= 1'b1;
        end else begin
          req.valid <= 1'b0;
        end
      end
      rsp.ready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 83) ||
                     (idle_mode == IDLE_BOTH && $urandom_range(99) < 18));
    end
  end

  // Monitor: updates the shadow state on accepted items and checks every result.
  always @(posedge clk) begin
    request_t it;
    reply_t   got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end else begin
      if (cfg_we) sh_radius = cfg_data;
      if (!rst && req.valid && req.ready) begin
        it = pending_q.pop_front();
        reply_q.push_back(predict_reply(it));
        in_flight <= 1'b0;
      end
      if (!rst && rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.path_length, rsp.path_cell};
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = reply_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  function automatic request_t make_item(hgap_cmd_t c, int cell_idx, int goal, bit blk,
                                         int pos);
    request_t it;
    it.cmd      = c;
    it.cell_idx = CELL_W'(cell_idx);
    it.goal     = CELL_W'(goal);
    it.blk      = blk;
    it.pos      = CELL_W'(pos);
    return it;
  endfunction

  function automatic int any_grid_cell();
    int c;
    do c = $urandom_range(grid_cells() - 1); while (!on_grid(c));
    return c;
  endfunction

  // Random item: mostly map edits, searches and reads on real cells.
  function automatic request_t random_item(int find_pct);
    request_t it;
    int roll;
    it = make_item(CMD_NOP, $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(1), $urandom_range(1023));
    roll = $urandom_range(99);
    if (roll < find_pct) begin
      it.cmd = CMD_FIND;
      if ($urandom_range(9) != 0) begin
        it.cell_idx = CELL_W'(any_grid_cell());
        it.goal     = CELL_W'(any_grid_cell());
      end
    end else if (roll < 55) begin
      it.cmd = CMD_SET;
      it.blk = ($urandom_range(99) < 30);
      if ($urandom_range(9) != 0) it.cell_idx = CELL_W'(any_grid_cell());
    end else if (roll < 95) begin
      it.cmd = CMD_READ;
      if ($urandom_range(5) != 0) it.pos = CELL_W'($urandom_range(12));
    end
    return it;
  endfunction

  task automatic drain_all();
    wait (pending_q.size() == 0 && !in_flight && reply_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_radius(int v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= RAD_W'(v);
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int radius, int count, int find_pct, idle_mode_t mode);
    set_radius(radius);
    idle_mode = mode;
    for (int n = 0; n < count; n++) pending_q.push_back(random_item(find_pct));
    drain_all();
  endtask

  initial begin
    sh_radius = RAD_RESET;
    sh_count  = 0;
    for (int i = 0; i < SLOTS; i++) begin
      sh_blocked[i] = 0;
      sh_parent[i] = NO_PARENT;
    end
    req.valid = 1'b0;
    req.cmd = CMD_NOP;
    req.cell_req = '0;
    req.goal_cell = '0;
    req.blocked = 1'b0;
    req.position = '0;
    rsp.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset radius, empty route, missing cells, trivial and short searches.
    pending_q.push_back(make_item(CMD_READ, 0, 0, 0, 0));
    pending_q.push_back(make_item(CMD_NOP, 1023, 1023, 1, 1023));
    pending_q.push_back(make_item(CMD_SET, 0, 0, 1, 0));
    pending_q.push_back(make_item(CMD_SET, 1023, 0, 1, 0));
    pending_q.push_back(make_item(CMD_FIND, 480, 1023, 0, 0));
    pending_q.push_back(make_item(CMD_FIND, 480, 480, 0, 0));
    pending_q.push_back(make_item(CMD_FIND, 480, 483, 0, 0));
    pending_q.push_back(make_item(CMD_READ, 0, 0, 0, 2));
    pending_q.push_back(make_item(CMD_READ, 0, 0, 0, 3));
    pending_q.push_back(make_item(CMD_FIND, 1023, 480, 0, 0));
    drain_all();

    // Smallest grid, then the out-of-range radius encoding zero.
    set_radius(1);
    pending_q.push_back(make_item(CMD_SET, 0, 0, 1, 0));
    pending_q.push_back(make_item(CMD_FIND, 0, 0, 0, 0));
    pending_q.push_back(make_item(CMD_SET, 1, 0, 0, 0));
    pending_q.push_back(make_item(CMD_SET, 0, 0, 0, 0));
    drain_all();
    set_radius(0);
    pending_q.push_back(make_item(CMD_FIND, 0, 0, 0, 0));
    drain_all();

    // Radius 2: isolated start, blocked goal next door, blocked start.
    set_radius(2);
    pending_q.push_back(make_item(CMD_SET, 2, 0, 1, 0));
    pending_q.push_back(make_item(CMD_SET, 3, 0, 1, 0));
    pending_q.push_back(make_item(CMD_SET, 4, 0, 1, 0));
    pending_q.push_back(make_item(CMD_SET, 5, 0, 1, 0));
    pending_q.push_back(make_item(CMD_FIND, 1, 7, 0, 0));
    pending_q.push_back(make_item(CMD_FIND, 1, 4, 0, 0));
    pending_q.push_back(make_item(CMD_FIND, 4, 6, 0, 0));
    pending_q.push_back(make_item(CMD_READ, 0, 0, 0, 0));
    pending_q.push_back(make_item(CMD_READ, 0, 0, 0, 1));
    drain_all();

    // Random phases over several radii and idle patterns.
    random_phase(31, 6, 10, IDLE_BOTH);
    random_phase(3, 18, 20, IDLE_SEND);
    random_phase(5, 18, 20, IDLE_RECV);
    random_phase(2, 18, 25, IDLE_NONE);
    random_phase(8, 14, 15, IDLE_BOTH);
    random_phase(16, 6, 10, IDLE_NONE);

    drain_all();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
design/hgap_pkg.sv
design/hgap_req_if.sv
design/hgap_rsp_if.sv
design/hgap_ram.sv
design/hgap_heur.sv
design/hex_grid_astar_path_core.sv
test/tb.sv
